@@ hdl/chm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the chained fd-to-handle map.
// Used by the cell row, the top level and the port checker; no dependencies.
package chm_pkg;

   // Fixed field widths of the request and response transfers
   localparam int MODE_W   = 2;
   localparam int KEY_W    = 16;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // Defaults for the top-level parameters
   localparam int NODES_DEFAULT    = 64;
   localparam int KEY_BITS_DEFAULT = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_GET   = 2'd0,
      MODE_SET   = 2'd1,
      MODE_ERASE = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_REPLACED  = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // Operation token that walks the cell row, one cell per cycle.
   // insert marks the second pass that claims the first free cell;
   // found means hit on the search pass and placed on the insert pass.
   typedef struct packed {
      logic                 valid;
      logic                 insert;
      mode_type             op;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
      logic                 found;
      logic                 free_seen;
      logic [VALUE_W-1:0]   old_value;
   } token_type;

endpackage

@@ hdl/chm_cell.sv @@
`timescale 1ns / 1ps
// One node of the map: in-use bit, key and handle, plus one token stage.
// Depends on chm_pkg for the token type and operation codes.
module chm_cell
   import chm_pkg::*;
#(
   parameter int KW = KEY_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  token_type tok_in,
   output token_type tok_out
);

   logic               in_use_ff, in_use_in;
   logic [KW-1:0]      key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   token_type          tok_ff, tok_in_next;
   logic               hit, claim;

   // Match on the search pass; claim the first free node on the insert pass
   assign hit = tok_in.valid && !tok_in.insert && (tok_in.op != MODE_NONE)
                && in_use_ff && (key_ff == tok_in.key[KW-1:0]);
   assign claim = tok_in.valid && tok_in.insert && !in_use_ff && !tok_in.found;

   // Update the node and the passing token
   always_comb begin
      in_use_in   = in_use_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      tok_in_next = tok_in;
      if (hit) begin
         tok_in_next.found     = 1'b1;
         tok_in_next.old_value = value_ff;
         case (tok_in.op)
            MODE_SET:   value_in  = tok_in.value;
            MODE_ERASE: in_use_in = 1'b0;
            default:    ;
         endcase
      end
      if (tok_in.valid && !tok_in.insert && !in_use_ff) begin
         tok_in_next.free_seen = 1'b1;
      end
      if (claim) begin
         in_use_in         = 1'b1;
         key_in            = tok_in.key[KW-1:0];
         value_in          = tok_in.value;
         tok_in_next.found = 1'b1;
      end
   end

   // Hold node contents; advance the token to the neighbor
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      tok_ff   <= tok_in_next;
      if (reset) begin
         in_use_ff    <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         in_use_ff <= in_use_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

@@ hdl/chained_hash_map_fd_to_handle_unit.sv @@
`timescale 1ns / 1ps
// Each item walks a token along the row of NODES cells, one cell per cycle:
// once for get, erase, none, replace and full, twice for an insert of a new key.
// The block takes one item at a time: busy is high from the start transfer
// until the result is strobed, and no new start is taken while busy.
// Reset (synchronous, active high) empties the map; no clearing pass is needed.
// Results are strobed for one cycle; the receiver cannot stall.
module chained_hash_map_fd_to_handle_unit
   import chm_pkg::*;
#(
   parameter int NODES    = NODES_DEFAULT,
   parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [VALUE_W-1:0]  req_new_value,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_old_value
);

   // Stored key width: only the low KEY_BITS bits of the port count, capped at KEY_W
   localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type          state_ff;
   token_type          launch_ff;
   token_type          link [NODES+1];
   token_type          last;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff, status_in;
   logic [VALUE_W-1:0] rsp_old_ff, old_in;
   mode_type           req_op;
   logic               relaunch;

   // Feed the row and chain the cells
   assign link[0] = launch_ff;
   assign last    = link[NODES];

   for (genvar i = 0; i < NODES; i++) begin : g_cell
      chm_cell #(.KW(KW)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_in (link[i]),
         .tok_out(link[i+1])
      );
   end

   // Decode the request; a set with a zero handle is an erase
   always_comb begin
      req_op = mode_type'(req_mode);
      if (req_op == MODE_SET && req_new_value == '0) begin
         req_op = MODE_ERASE;
      end
   end

   // Start an insert pass when a set missed and a free node exists
   assign relaunch = last.valid && !last.insert && (last.op == MODE_SET)
                     && !last.found && last.free_seen;

   // Form the result from the token leaving the row
   always_comb begin
      status_in = STATUS_NOT_FOUND;
      old_in    = '0;
      if (last.insert) begin
         status_in = STATUS_DONE;
      end else begin
         case (last.op)
            MODE_GET: begin
               if (last.found) begin
                  status_in = STATUS_DONE;
                  old_in    = last.old_value;
               end
            end
            MODE_SET: begin
               if (last.found) begin
                  status_in = STATUS_REPLACED;
                  old_in    = last.old_value;
               end else begin
                  status_in = STATUS_FULL;
               end
            end
            MODE_ERASE: begin
               if (last.found) begin
                  status_in = STATUS_REPLACED;
                  old_in    = last.old_value;
               end
            end
            default: status_in = STATUS_NOT_FOUND;
         endcase
      end
   end

   // Sequence one item at a time: launch, optional insert pass, respond
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         launch_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         launch_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  launch_ff.valid     <= 1'b1;
                  launch_ff.insert    <= 1'b0;
                  launch_ff.op        <= req_op;
                  launch_ff.key       <= req_key;
                  launch_ff.value     <= req_new_value;
                  launch_ff.found     <= 1'b0;
                  launch_ff.free_seen <= 1'b0;
                  launch_ff.old_value <= '0;
                  state_ff            <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (relaunch) begin
                  launch_ff        <= last;
                  launch_ff.insert <= 1'b1;
                  launch_ff.found  <= 1'b0;
               end else if (last.valid) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_in;
                  rsp_old_ff    <= old_in;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_old_value = rsp_old_ff;

endmodule

@@ hdl/chm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the fd-to-handle map, bound to the top level.
// Depends on chm_pkg for field widths and status codes.
module chm_checker
   import chm_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [VALUE_W-1:0]  rsp_old_value
);

   // A taken request makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not raise busy");

   // A result only follows a busy cycle, and busy is low while it is shown
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result without an item in flight");

   // One result per item: the result strobe never repeats back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe repeated");

   // Miss and full report no handle
   a_rsp_zero_old: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_NOT_FOUND || rsp_status == STATUS_FULL))
      |-> (rsp_old_value == '0))
      else $error("nonzero handle on miss or full");

endmodule

bind chained_hash_map_fd_to_handle_unit chm_checker u_chm_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_status   (rsp_status),
   .rsp_old_value(rsp_old_value)
);

@@ dv/chained_hash_map_fd_to_handle_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the chained fd-to-handle map: a directed table, then random
// get/set/erase traffic checked against a map kept in the testbench. Needs chm_pkg and the top.
module chained_hash_map_fd_to_handle_unit_test;
   import chm_pkg::*;

   localparam int NODES    = NODES_DEFAULT;
   localparam int KEY_BITS = KEY_BITS_DEFAULT;
   localparam logic [KEY_W-1:0] FD_MASK = KEY_W'((64'd1 << KEY_BITS) - 1);
   // Stall limit without a transfer: well above an insert plus the longest sender gap
   localparam int STALL_LIMIT = 8 * (2 * NODES + 8);
   localparam int DIRECTED_ROWS = 18;
   localparam int SEGMENTS = 9;
   localparam int SEGMENT_ITEMS = 100;
   localparam int HOT_FDS = 80;

   typedef struct packed {
      status_type           status;
      logic [VALUE_W-1:0]   old_value;
   } map_reply;

   typedef struct packed {
      mode_type             op;
      logic [KEY_W-1:0]     fd;
      logic [VALUE_W-1:0]   handle;
      logic                 known;
      status_type           want_status;
      logic [VALUE_W-1:0]   want_old;
   } stim_row;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [MODE_W-1:0]   req_mode = '0;
   logic [KEY_W-1:0]    req_key = '0;
   logic [VALUE_W-1:0]  req_new_value = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_old_value;

   logic [VALUE_W-1:0] handle_by_fd [logic [KEY_W-1:0]];
   map_reply           replies_due [$];
   map_reply           due;
   int                 fail_count = 0;
   int                 quiet_cycles = 0;
   logic [KEY_W-1:0]   hot_fds [HOT_FDS];

   // Extremes, every operation and each corner; typed replies only where obvious
   stim_row directed_rows [DIRECTED_ROWS] = '{
      '{MODE_GET,   16'h0000, 32'h0,        1'b1, STATUS_NOT_FOUND, 32'h0},
      '{MODE_ERASE, 16'hffff, 32'h0,        1'b1, STATUS_NOT_FOUND, 32'h0},
      '{MODE_NONE,  16'h0005, 32'h7,        1'b1, STATUS_NOT_FOUND, 32'h0},
      '{MODE_SET,   16'h0000, 32'hffffffff, 1'b1, STATUS_DONE,      32'h0},
      '{MODE_GET,   16'h0000, 32'h0,        1'b1, STATUS_DONE,      32'hffffffff},
      '{MODE_SET,   16'h0040, 32'h1,        1'b0, STATUS_DONE,      32'h0},
      '{MODE_SET,   16'hffff, 32'h80000000, 1'b1, STATUS_DONE,      32'h0},
      '{MODE_SET,   16'h0000, 32'h12345678, 1'b1, STATUS_REPLACED,  32'hffffffff},
      '{MODE_GET,   16'h0040, 32'hffffffff, 1'b0, STATUS_DONE,      32'h0},
      '{MODE_SET,   16'h0040, 32'h0,        1'b1, STATUS_REPLACED,  32'h1},
      '{MODE_GET,   16'h0040, 32'h0,        1'b1, STATUS_NOT_FOUND, 32'h0},
      '{MODE_ERASE, 16'h0000, 32'h0,        1'b1, STATUS_REPLACED,  32'h12345678},
      '{MODE_ERASE, 16'h0000, 32'h0,        1'b1, STATUS_NOT_FOUND, 32'h0},
      '{MODE_NONE,  16'hffff, 32'hffffffff, 1'b1, STATUS_NOT_FOUND, 32'h0},
      '{MODE_GET,   16'hffff, 32'h0,        1'b1, STATUS_DONE,      32'h80000000},
      '{MODE_SET,   16'h1234, 32'h0,        1'b1, STATUS_NOT_FOUND, 32'h0},
      '{MODE_SET,   16'h7fc0, 32'h55aa55aa, 1'b0, STATUS_DONE,      32'h0},
      '{MODE_ERASE, 16'hffff, 32'h0,        1'b1, STATUS_REPLACED,  32'h80000000}
   };

   chained_hash_map_fd_to_handle_unit #(
      .NODES   (NODES),
      .KEY_BITS(KEY_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_key      (req_key),
      .req_new_value(req_new_value),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_old_value(rsp_old_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one operation to the map and return the reply it owes
   function automatic map_reply next_map_reply(mode_type op, logic [KEY_W-1:0] key,
                                               logic [VALUE_W-1:0] handle);
      map_reply         r;
      logic [KEY_W-1:0] fd;
      mode_type         act;
      fd = key & FD_MASK;
      act = op;
      r.status = STATUS_NOT_FOUND;
      r.old_value = '0;
      // a set with a zero handle removes the key
      if (act == MODE_SET && handle == '0)
         act = MODE_ERASE;
      case (act)
         MODE_GET: begin
            if (handle_by_fd.exists(fd)) begin
               r.status = STATUS_DONE;
               r.old_value = handle_by_fd[fd];
            end
         end
         MODE_ERASE: begin
            if (handle_by_fd.exists(fd)) begin
               r.status = STATUS_REPLACED;
               r.old_value = handle_by_fd[fd];
               handle_by_fd.delete(fd);
            end
         end
         MODE_SET: begin
            // replace needs no node, so it works with the pool full
            if (handle_by_fd.exists(fd)) begin
               r.status = STATUS_REPLACED;
               r.old_value = handle_by_fd[fd];
               handle_by_fd[fd] = handle;
            end else if (handle_by_fd.num() < NODES) begin
               r.status = STATUS_DONE;
               handle_by_fd[fd] = handle;
            end else begin
               r.status = STATUS_FULL;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Offer one request and hold it until the transfer, then record its reply
   task automatic send_item(stim_row row);
      map_reply r;
      @(negedge clock);
      start = 1'b1;
      req_mode = row.op;
      req_key = row.fd;
      req_new_value = row.handle;
      do @(posedge clock); while (busy);
      r = next_map_reply(row.op, row.fd, row.handle);
      if (row.known) begin
         r.status = row.want_status;
         r.old_value = row.want_old;
      end
      replies_due.push_back(r);
   endtask

   // Drop start for a number of cycles
   task automatic hold_off(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Drop start and wait for every outstanding reply
   task automatic drain_replies();
      @(negedge clock);
      start = 1'b0;
      while (replies_due.size() != 0) @(negedge clock);
   endtask

   function automatic logic [KEY_W-1:0] fresh_hot_fd();
      // half the hot keys take one of eight values in their low six bits
      if ($urandom_range(0, 1))
         return {KEY_W'($urandom) & ~KEY_W'(63)} | KEY_W'($urandom_range(0, 7) * 9);
      return KEY_W'($urandom);
   endfunction

   function automatic stim_row random_row(int style);
      stim_row row;
      int      pick;
      int      v;
      pick = $urandom_range(0, 99);
      // fill, mixed and drain phases weight the operations differently
      case (style)
         0:       row.op = pick < 60 ? MODE_SET : pick < 75 ? MODE_GET :
                           pick < 94 ? MODE_ERASE : MODE_NONE;
         1:       row.op = pick < 35 ? MODE_SET : pick < 65 ? MODE_GET :
                           pick < 94 ? MODE_ERASE : MODE_NONE;
         default: row.op = pick < 15 ? MODE_SET : pick < 45 ? MODE_GET :
                           pick < 95 ? MODE_ERASE : MODE_NONE;
      endcase
      if ($urandom_range(0, 99) < 75)
         row.fd = hot_fds[$urandom_range(0, HOT_FDS - 1)];
      else
         row.fd = KEY_W'($urandom);
      v = $urandom_range(0, 99);
      row.handle = v < 8 ? '0 : v < 12 ? '1 : VALUE_W'($urandom);
      row.known = 1'b0;
      row.want_status = STATUS_DONE;
      row.want_old = '0;
      return row;
   endfunction

   // Compare each strobed reply with the oldest one owed; watch for a stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               $error("unexpected reply: rsp_status %0d rsp_old_value %h",
                      rsp_status, rsp_old_value);
               fail_count++;
            end else begin
               due = replies_due.pop_front();
               if (rsp_status !== due.status) begin
                  $error("rsp_status: expected %0d, actual %0d", due.status, rsp_status);
                  fail_count++;
               end
               if (rsp_old_value !== due.old_value) begin
                  $error("rsp_old_value: expected %h, actual %h", due.old_value,
                         rsp_old_value);
                  fail_count++;
               end
            end
         end
         if (rsp_valid || (start && !busy)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      int burst_left;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i]);
      drain_replies();

      foreach (hot_fds[i])
         hot_fds[i] = fresh_hot_fd();
      burst_left = 0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         // swap part of the hot keys so later phases meet stale entries
         for (int j = 0; j < 16; j++)
            hot_fds[$urandom_range(0, HOT_FDS - 1)] = fresh_hot_fd();
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            // bursts of back-to-back offers, mostly separated by a gap of random length
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               if ($urandom_range(0, 2) != 0)
                  hold_off($urandom_range(1, 2 * NODES + 8));
            end
            send_item(random_row(seg % 3));
            burst_left--;
         end
         if (seg % 3 == 1)
            drain_replies();
      end

      drain_replies();
      repeat (2 * NODES + 8) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/chm_pkg.sv
hdl/chm_cell.sv
hdl/chained_hash_map_fd_to_handle_unit.sv
hdl/chm_checker.sv
dv/chained_hash_map_fd_to_handle_unit_test.sv
